### rtl/mdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mdc_pkg;

    // Timer and register widths.
    localparam int TIMER_BITS    = 20;
    localparam int LIMIT_BITS    = 20;
    localparam int SAMPLE_BITS   = 10;
    localparam int CMP_BITS      = (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 20;
    localparam int STATE_BITS    = 3;

    // Register reset values.
    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET     = SAMPLE_BITS'(310);
    localparam logic [LIMIT_BITS-1:0]  OVERLOAD_RESET      = LIMIT_BITS'(200);
    localparam logic [LIMIT_BITS-1:0]  OPERATION_RESET     = LIMIT_BITS'(10000);
    localparam logic [LIMIT_BITS-1:0]  MIN_SUCCESS_RESET   = LIMIT_BITS'(1000);
    localparam logic [TIMER_BITS-1:0]  TIMER_MAX           = {TIMER_BITS{1'b1}};

    // Operation codes carried with each input word.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_THRESHOLD       = 2'd0,
        REG_OVERLOAD_LIMIT  = 2'd1,
        REG_OPERATION_LIMIT = 2'd2,
        REG_MIN_SUCCESS     = 2'd3
    } cfg_idx_t;

    // Door mode, kept one-hot inside the block.
    typedef enum logic [4:0] {
        MODE_ERROR   = 5'b00001,
        MODE_OPENING = 5'b00010,
        MODE_CLOSING = 5'b00100,
        MODE_OPENED  = 5'b01000,
        MODE_CLOSED  = 5'b10000
    } mode_t;

    // Door state codes as seen on the result port.
    localparam logic [STATE_BITS-1:0] DS_ERROR   = 3'd0;
    localparam logic [STATE_BITS-1:0] DS_OPENING = 3'd1;
    localparam logic [STATE_BITS-1:0] DS_CLOSING = 3'd2;
    localparam logic [STATE_BITS-1:0] DS_OPENED  = 3'd3;
    localparam logic [STATE_BITS-1:0] DS_CLOSED  = 3'd4;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] current_threshold;
        logic [LIMIT_BITS-1:0]  overload_limit;
        logic [LIMIT_BITS-1:0]  operation_limit;
        logic [LIMIT_BITS-1:0]  min_success;
    } cfg_t;

    typedef struct packed {
        logic [STATE_BITS-1:0] door_state;
        logic                  open_drive;
        logic                  close_drive;
        logic                  timeout_seen;
        logic                  blocked_seen;
    } result_t;

    function automatic logic [STATE_BITS-1:0] encode_mode(input mode_t m);
        logic [STATE_BITS-1:0] code;
        case (m)
            MODE_OPENING: code = DS_OPENING;
            MODE_CLOSING: code = DS_CLOSING;
            MODE_OPENED:  code = DS_OPENED;
            MODE_CLOSED:  code = DS_CLOSED;
            default:      code = DS_ERROR;
        endcase
        return code;
    endfunction

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (v == TIMER_MAX) ? v : v + TIMER_BITS'(1);
    endfunction

endpackage

`default_nettype wire

### rtl/motor_door_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Door motor controller. Each input word is either a 1 ms tick carrying a motor
// current sample or an open or close command; each accepted word yields exactly
// one result word with the door state, both motor drives and the timeout and
// blocked flags of that word. The block accepts one word per clock cycle while
// the result side is not stalled; an accepted word is held in the input register,
// and once the result slot is free the state update and the result register load
// happen together at the same clock edge. Register writes take effect at the
// next clock edge and are meant to be made while no word is in flight.
module motor_door_controller_unit
    import mdc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    // Input stream.
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [15:0]              s_tdata,   // [9:0] current_sample
    input  wire logic [1:0]               s_tuser,   // [1:0] operation

    // Result stream.
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [7:0]                    m_tdata,   // [2:0] door_state, [3] open_drive,
                                                     // [4] close_drive, [5] timeout_seen,
                                                     // [6] blocked_seen

    // Register write port.
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    logic                   in_valid_reg, in_valid_next;
    op_t                    op_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_data_reg;
    logic                   out_ready;
    logic                   advance;
    logic                   in_load;
    cfg_t                   cfg;
    result_t                res;

    mdc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mdc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .op      (op_reg),
        .sample  (sample_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Pipeline handshake: the input word moves on when the result slot is free.
    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign in_load   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_load ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            op_reg     <= op_t'(s_tuser);
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (advance) begin
            out_data_reg <= {1'b0, res.blocked_seen, res.timeout_seen,
                             res.close_drive, res.open_drive, res.door_state};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // A word taken from the input register shows up as a result next cycle.
    a_advance_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("accepted word did not reach the result register");

    // A stalled result with a waiting input word holds off the input side.
    a_full_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full");

    // The padding bit of a result word is always zero.
    a_result_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7])
        else $error("result padding bit set");
`endif

endmodule

`default_nettype wire

### rtl/mdc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module mdc_cfg
    import mdc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index and truncate the data to the register width.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                REG_THRESHOLD:       cfg_next.current_threshold = cfg_wdata[SAMPLE_BITS-1:0];
                REG_OVERLOAD_LIMIT:  cfg_next.overload_limit    = cfg_wdata[LIMIT_BITS-1:0];
                REG_OPERATION_LIMIT: cfg_next.operation_limit   = cfg_wdata[LIMIT_BITS-1:0];
                REG_MIN_SUCCESS:     cfg_next.min_success       = cfg_wdata[LIMIT_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.current_threshold <= THRESHOLD_RESET;
            cfg_reg.overload_limit    <= OVERLOAD_RESET;
            cfg_reg.operation_limit   <= OPERATION_RESET;
            cfg_reg.min_success       <= MIN_SUCCESS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/mdc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mdc_core
    import mdc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   step_en,
    input  wire op_t                    op,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire cfg_t                   cfg,
    output result_t                     res
);

    mode_t                 mode_reg, mode_next;
    logic                  open_drive_reg, open_drive_next;
    logic                  close_drive_reg, close_drive_next;
    logic                  op_active_reg, op_active_next;
    logic [TIMER_BITS-1:0] op_elapsed_reg, op_elapsed_next;
    logic                  ov_active_reg, ov_active_next;
    logic [TIMER_BITS-1:0] ov_elapsed_reg, ov_elapsed_next;
    logic                  timeout_seen;
    logic                  blocked_seen;

    // One full update of the door state for the word at the head of the pipeline.
    always_comb begin
        logic early;
        mode_next        = mode_reg;
        open_drive_next  = open_drive_reg;
        close_drive_next = close_drive_reg;
        op_active_next   = op_active_reg;
        op_elapsed_next  = op_elapsed_reg;
        ov_active_next   = ov_active_reg;
        ov_elapsed_next  = ov_elapsed_reg;
        timeout_seen     = 1'b0;
        blocked_seen     = 1'b0;
        early            = 1'b0;
        case (op)
            OP_OPEN: begin
                if (mode_reg != MODE_OPENING) begin
                    open_drive_next  = 1'b1;
                    close_drive_next = 1'b0;
                    op_active_next   = 1'b1;
                    op_elapsed_next  = '0;
                    mode_next        = MODE_OPENING;
                end
            end
            OP_CLOSE: begin
                if (mode_reg != MODE_CLOSING) begin
                    open_drive_next  = 1'b0;
                    close_drive_next = 1'b1;
                    op_active_next   = 1'b1;
                    op_elapsed_next  = '0;
                    mode_next        = MODE_CLOSING;
                end
            end
            OP_TICK: begin
                // Advance running timers.
                if (op_active_reg) begin
                    op_elapsed_next = sat_inc(op_elapsed_reg);
                end
                if (ov_active_reg) begin
                    ov_elapsed_next = sat_inc(ov_elapsed_reg);
                end

                // An error state retries by opening.
                if (mode_reg == MODE_ERROR) begin
                    open_drive_next  = 1'b1;
                    close_drive_next = 1'b0;
                    op_active_next   = 1'b1;
                    op_elapsed_next  = '0;
                    mode_next        = MODE_OPENING;
                end

                // Operation timeout.
                if (op_active_next &&
                    (CMP_BITS'(op_elapsed_next) > CMP_BITS'(cfg.operation_limit))) begin
                    timeout_seen     = 1'b1;
                    open_drive_next  = 1'b0;
                    close_drive_next = 1'b0;
                    if (mode_next == MODE_OPENING) begin
                        mode_next       = MODE_OPENED;
                        op_active_next  = 1'b0;
                        op_elapsed_next = '0;
                    end else begin
                        mode_next = MODE_ERROR;
                    end
                end

                // Load detection from the current sample.
                if (sample < cfg.current_threshold) begin
                    if (!ov_active_reg) begin
                        ov_active_next  = 1'b1;
                        ov_elapsed_next = '0;
                    end
                end else begin
                    ov_active_next  = 1'b0;
                    ov_elapsed_next = '0;
                end

                // Blocked door ends the motion.
                if (ov_active_next &&
                    (CMP_BITS'(ov_elapsed_next) > CMP_BITS'(cfg.overload_limit))) begin
                    early = op_active_next && (op_elapsed_next != '0) &&
                            (CMP_BITS'(op_elapsed_next) < CMP_BITS'(cfg.min_success));
                    blocked_seen     = 1'b1;
                    open_drive_next  = 1'b0;
                    close_drive_next = 1'b0;
                    if (mode_next == MODE_CLOSING && early) begin
                        mode_next = MODE_ERROR;
                    end else if (mode_next == MODE_CLOSING) begin
                        mode_next       = MODE_CLOSED;
                        op_active_next  = 1'b0;
                        op_elapsed_next = '0;
                    end else if (mode_next == MODE_OPENING) begin
                        mode_next       = MODE_OPENED;
                        op_active_next  = 1'b0;
                        op_elapsed_next = '0;
                    end else begin
                        mode_next = MODE_ERROR;
                    end
                end
            end
            default: begin
                // Unused operation code: report the state unchanged.
            end
        endcase
    end

    // State advances only when the word moves to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_ERROR;
            open_drive_reg  <= 1'b0;
            close_drive_reg <= 1'b0;
            op_active_reg   <= 1'b0;
            op_elapsed_reg  <= '0;
            ov_active_reg   <= 1'b0;
            ov_elapsed_reg  <= '0;
        end else if (step_en) begin
            mode_reg        <= mode_next;
            open_drive_reg  <= open_drive_next;
            close_drive_reg <= close_drive_next;
            op_active_reg   <= op_active_next;
            op_elapsed_reg  <= op_elapsed_next;
            ov_active_reg   <= ov_active_next;
            ov_elapsed_reg  <= ov_elapsed_next;
        end
    end

    assign res.door_state   = encode_mode(mode_next);
    assign res.open_drive   = open_drive_next;
    assign res.close_drive  = close_drive_next;
    assign res.timeout_seen = timeout_seen;
    assign res.blocked_seen = blocked_seen;

`ifndef SYNTH
    // The open drive runs exactly while the door is opening.
    a_open_drive_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        open_drive_reg == (mode_reg == MODE_OPENING))
        else $error("open drive does not match opening mode");

    // The close drive runs exactly while the door is closing.
    a_close_drive_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        close_drive_reg == (mode_reg == MODE_CLOSING))
        else $error("close drive does not match closing mode");

    // A finished motion leaves the operation timer stopped and cleared.
    a_timer_idle_at_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_OPENED || mode_reg == MODE_CLOSED) |->
            (!op_active_reg && op_elapsed_reg == '0))
        else $error("operation timer running in a rest state");

    // A blocked report always stops both drives.
    a_block_stops_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && blocked_seen) |=> (!open_drive_reg && !close_drive_reg))
        else $error("motor still driven after block");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mdc_pkg::*;

    // Predicts the door controller word by word and checks its result stream.
    class door_checker;
        cfg_t                  limits;
        logic [STATE_BITS-1:0] mode;
        logic                  open_on;
        logic                  close_on;
        logic                  op_run;
        logic                  load_run;
        logic [TIMER_BITS-1:0] op_ms;
        logic [TIMER_BITS-1:0] load_ms;
        result_t               awaited_status[$];
        int                    failures;

        function new();
            limits.current_threshold = THRESHOLD_RESET;
            limits.overload_limit    = OVERLOAD_RESET;
            limits.operation_limit   = OPERATION_RESET;
            limits.min_success       = MIN_SUCCESS_RESET;
            mode     = DS_ERROR;
            open_on  = 1'b0;
            close_on = 1'b0;
            op_run   = 1'b0;
            load_run = 1'b0;
            op_ms    = '0;
            load_ms  = '0;
            failures = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_THRESHOLD:       limits.current_threshold = value[SAMPLE_BITS-1:0];
                REG_OVERLOAD_LIMIT:  limits.overload_limit    = value[LIMIT_BITS-1:0];
                REG_OPERATION_LIMIT: limits.operation_limit   = value[LIMIT_BITS-1:0];
                REG_MIN_SUCCESS:     limits.min_success       = value[LIMIT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited_status.size();
        endfunction

        // Counters hold at all ones instead of wrapping.
        function logic [TIMER_BITS-1:0] bump(logic [TIMER_BITS-1:0] v);
            return (v == TIMER_MAX) ? v : v + 1'b1;
        endfunction

        // A command toward a new direction restarts the run; repeating it does nothing.
        function void drive_toward(logic [STATE_BITS-1:0] target);
            if (mode != target) begin
                open_on  = (target == DS_OPENING);
                close_on = (target == DS_CLOSING);
                op_run   = 1'b1;
                op_ms    = '0;
                mode     = target;
            end
        endfunction

        function void end_run(logic [STATE_BITS-1:0] target);
            mode   = target;
            op_run = 1'b0;
            op_ms  = '0;
        endfunction

        function void note_word(op_t op, logic [SAMPLE_BITS-1:0] reading);
            result_t status;
            logic    early;
            status.timeout_seen = 1'b0;
            status.blocked_seen = 1'b0;
            case (op)
                OP_OPEN:  drive_toward(DS_OPENING);
                OP_CLOSE: drive_toward(DS_CLOSING);
                OP_TICK: begin
                    if (op_run)
                        op_ms = bump(op_ms);
                    if (load_run)
                        load_ms = bump(load_ms);
                    // A tick in the error state retries by opening.
                    if (mode == DS_ERROR)
                        drive_toward(DS_OPENING);
                    // Operation timeout: only an opening run ends well.
                    if (op_run && op_ms > limits.operation_limit) begin
                        status.timeout_seen = 1'b1;
                        open_on  = 1'b0;
                        close_on = 1'b0;
                        if (mode == DS_OPENING)
                            end_run(DS_OPENED);
                        else
                            mode = DS_ERROR;
                    end
                    // Low current reading means the motor is under load.
                    if (reading < limits.current_threshold) begin
                        if (!load_run) begin
                            load_run = 1'b1;
                            load_ms  = '0;
                        end
                    end else begin
                        load_run = 1'b0;
                        load_ms  = '0;
                    end
                    // Blocked door: end of travel, or an error if it came too soon.
                    if (load_run && load_ms > limits.overload_limit) begin
                        early = op_run && op_ms != '0 && op_ms < limits.min_success;
                        status.blocked_seen = 1'b1;
                        open_on  = 1'b0;
                        close_on = 1'b0;
                        if (mode == DS_CLOSING && early)
                            mode = DS_ERROR;
                        else if (mode == DS_CLOSING)
                            end_run(DS_CLOSED);
                        else if (mode == DS_OPENING)
                            end_run(DS_OPENED);
                        else
                            mode = DS_ERROR;
                    end
                end
                default: ;
            endcase
            status.door_state  = mode;
            status.open_drive  = open_on;
            status.close_drive = close_on;
            awaited_status.push_back(status);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_word(logic [7:0] data);
            result_t want;
            if (awaited_status.size() == 0) begin
                $error("result word 0x%02h arrived with nothing outstanding", data);
                failures++;
                return;
            end
            want = awaited_status.pop_front();
            compare_field("door_state", want.door_state, data[2:0]);
            compare_field("open_drive", want.open_drive, data[3]);
            compare_field("close_drive", want.close_drive, data[4]);
            compare_field("timeout_seen", want.timeout_seen, data[5]);
            compare_field("blocked_seen", want.blocked_seen, data[6]);
        endfunction
    endclass

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BUDGET = 292;
    localparam int HOLD_CYCLES  = 300;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [15:0]              s_tdata   = '0;
    logic [1:0]               s_tuser   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [7:0]               m_tdata;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    door_checker sb = new();

    bit steady       = 1'b0;
    bit hold_request = 1'b0;
    int phase_count  = 0;
    int cur_thr      = 310;
    int op_span      = 44;
    int load_span    = 11;
    int cycles       = 0;

    motor_door_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Every result word taken by the receiver is checked here.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    // Receiver: random stalls per word, and one long hold-off on request.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_word(op_t op, logic [SAMPLE_BITS-1:0] reading);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 16'(reading);
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, reading);
        if (op != OP_NONE)
            phase_count++;
    endtask

    // Reading source: 0 at or above the threshold, 1 below it, 2 anything.
    function automatic logic [SAMPLE_BITS-1:0] pick_reading(int how);
        if (how == 0)
            return $urandom_range(cur_thr, 1023);
        else if (how == 1 && cur_thr > 0)
            return $urandom_range(0, cur_thr - 1);
        return $urandom_range(0, 1023);
    endfunction

    task automatic tick_run(int n, int how);
        repeat (n) send_word(OP_TICK, pick_reading(how));
    endtask

    // Wait until every outstanding word has produced its result.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_phase(int thr, int ovl, int oplim, int minok);
        int        vals[4];
        cfg_idx_t  idx[4];
        vals = '{thr, ovl, oplim, minok};
        idx  = '{REG_THRESHOLD, REG_OVERLOAD_LIMIT, REG_OPERATION_LIMIT, REG_MIN_SUCCESS};
        cur_thr   = thr;
        op_span   = ((oplim < 40) ? oplim : 40) + 4;
        load_span = ((ovl < 8) ? ovl : 8) + 3;
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= CFG_DATA_BITS'(vals[i]);
            @(posedge aclk);
            sb.set_register(idx[i], CFG_DATA_BITS'(vals[i]));
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // One random stretch of traffic, mostly complete door motions.
    task automatic run_sequence();
        int  kind;
        op_t cmd;
        kind   = $urandom_range(0, 9);
        steady = ($urandom_range(0, 4) == 0);
        if (kind < 7) begin
            cmd = $urandom_range(0, 1) ? OP_OPEN : OP_CLOSE;
            send_word(cmd, pick_reading(2));
            if ($urandom_range(0, 5) == 0)
                send_word(cmd, pick_reading(2));
            tick_run($urandom_range(0, op_span), 0);
            if ($urandom_range(0, 3) != 0)
                tick_run($urandom_range(1, load_span), 1);
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 6))
                send_word(op_t'($urandom_range(0, 3)), pick_reading(2));
        end else if (kind == 8) begin
            tick_run($urandom_range(1, 10), 2);
        end else begin
            send_word(OP_NONE, pick_reading(2));
            send_word($urandom_range(0, 1) ? OP_OPEN : OP_CLOSE, pick_reading(2));
        end
    endtask

    // Main stimulus.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: error retries opening, repeated and ignored commands.
        send_word(OP_TICK, 10'd1023);
        send_word(OP_NONE, 10'd0);
        send_word(OP_CLOSE, 10'd0);
        send_word(OP_CLOSE, 10'd1023);
        send_word(OP_TICK, 10'd0);
        settle();

        // Short limits so that every outcome shows up within a few ticks.
        set_phase(512, 1, 6, 4);
        send_word(OP_CLOSE, 10'd0);
        send_word(OP_TICK, 10'd0);
        send_word(OP_TICK, 10'd511);
        send_word(OP_TICK, 10'd0);      // closing blocked too soon
        send_word(OP_TICK, 10'd512);    // error retries opening
        tick_run(7, 0);                 // opening times out into opened
        send_word(OP_CLOSE, 10'd1023);
        tick_run(3, 0);
        tick_run(3, 1);                 // closing blocked late enough: closed
        send_word(OP_OPEN, 10'd0);
        send_word(OP_OPEN, 10'd0);
        tick_run(3, 1);                 // opening blocked: opened
        tick_run(3, 1);                 // blocked while opened: error
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_phase(512, 3, 20, 8);
                1: set_phase(0, 0, 0, 0);
                2: set_phase(1023, 1048575, 12, 1048575);
                3: set_phase($urandom_range(1, 1023), $urandom_range(0, 8),
                             $urandom_range(4, 40), $urandom_range(0, 45));
                4: set_phase(1, 2, 1048575, 5);
                default: set_phase($urandom_range(0, 1023), $urandom_range(0, 5),
                                   $urandom_range(2, 30), $urandom_range(0, 30));
            endcase
            // Let the result side back up so the input side has to stall.
            if (phase == 0 || phase == 3)
                hold_request = 1'b1;
            phase_count = 0;
            while (phase_count < PHASE_BUDGET)
                run_sequence();
            steady = 1'b0;
            settle();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
rtl/mdc_pkg.sv
rtl/mdc_cfg.sv
rtl/mdc_core.sv
rtl/motor_door_controller_unit.sv
sim/testbench.sv
